FILE: src/b2s_pkg.sv
// Shared constants, types and the message schedule for the BLAKE2s engine.
package b2s_pkg;

  typedef logic [31:0] word_t;
  typedef logic [3:0][31:0] row_t;

  // One column of the working vector: the four words that a mixing step touches.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  localparam logic [7:0][31:0] B2S_IV = {
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };

  // Configuration register indexes.
  localparam logic [1:0] REG_DLEN = 2'd0;
  localparam logic [1:0] REG_KLEN = 2'd1;
  localparam logic [1:0] REG_SALT = 2'd2;

  localparam logic [3:0] LAST_ROUND = 4'd9;
  localparam logic [6:0] BLOCK_BYTES = 7'd64;
  localparam logic [5:0] MAX_DIGEST = 6'd32;
  localparam logic [5:0] MAX_KEY = 6'd32;
  localparam logic [2:0] WORD_BYTES = 3'd4;

  // Message word index used by round r at step s (two steps per mixing call).
  function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] s);
    logic [63:0] row;
    case (r)
      4'd0: row = 64'hFEDCBA9876543210;
      4'd1: row = 64'h357B20C16DF984AE;
      4'd2: row = 64'h491763EADF250C8B;
      4'd3: row = 64'h8F04A562EBCD1397;
      4'd4: row = 64'hD386CB1EFA427509;
      4'd5: row = 64'h91EF57D438B0A6C2;
      4'd6: row = 64'hB8293670A4DEF15C;
      4'd7: row = 64'hA2684F05931CE7BD;
      4'd8: row = 64'h5A417D2C803B9EF6;
      4'd9: row = 64'h0DC3E9BF5167482A;
      default: row = 64'h0;
    endcase
    return row[{s, 2'b00} +: 4];
  endfunction

endpackage

FILE: src/b2s_mix.sv
// Shared mixing unit: one half of the BLAKE2s G function per cycle.
module b2s_mix (
  input  b2s_pkg::quad_t q_i,
  input  b2s_pkg::word_t x_i,
  input  logic           second_i,
  output b2s_pkg::quad_t q_o
);

  b2s_pkg::word_t a1;
  b2s_pkg::word_t d0;
  b2s_pkg::word_t d1;
  b2s_pkg::word_t c1;
  b2s_pkg::word_t b0;
  b2s_pkg::word_t b1;

  always_comb begin
    a1 = q_i.a + q_i.b + x_i;
    d0 = q_i.d ^ a1;
    // First half rotates by 16 and 12, second half by 8 and 7.
    d1 = second_i ? {d0[7:0], d0[31:8]} : {d0[15:0], d0[31:16]};
    c1 = q_i.c + d1;
    b0 = q_i.b ^ c1;
    b1 = second_i ? {b0[6:0], b0[31:7]} : {b0[11:0], b0[31:12]};
    q_o.a = a1;
    q_o.b = b1;
    q_o.c = c1;
    q_o.d = d1;
  end

endmodule

FILE: src/blake2s_hash_engine.sv
// Top level of the BLAKE2s hash engine: buffer, sequencer, chain and digest output.
//
//  Channel | Ports                      | Contents
//  in      | in_tvalid/tready/tdata/tlast  | tdata: message_word, byte_count; tlast: end
//  out     | out_tvalid/tready/tdata/tlast | tdata: digest_word, digest_bytes; tlast: last
//  cfg     | cfg_we/cfg_index/cfg_wdata    | digest_length, key_length, salt_value
//
// An item is taken in ST_IDLE and its valid bytes are written one by one in ST_PUT.
// Every 64 bytes that are followed by more data cost one block compression:
// ST_PUT sees the full buffer, ST_PRE primes the buffer read, ST_COMP runs 160
// half-G steps on the single mixing unit and ST_FIN folds the vector into the
// chain. The last item adds the final compression and then one digest word per
// transfer. The engine takes no item while it works or while digest words wait;
// out_tready low simply holds the current word. Reset (rst_n low, synchronous)
// clears the sequencer and counters and returns the configuration to its defaults.
module blake2s_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] message_word, [34:32] byte_count, [39:35] zero
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] digest_bytes, [39:35] zero
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PUT, ST_PRE, ST_COMP, ST_FIN, ST_OUT
  } state_t;

  localparam logic [5:0] MAX_DIGEST_C = b2s_pkg::MAX_DIGEST;

  state_t state_r;

  // Configuration registers.
  logic [5:0]  dlen_r;
  logic [5:0]  klen_r;
  logic [63:0] salt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlen_r <= MAX_DIGEST_C;
      klen_r <= '0;
      salt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        b2s_pkg::REG_DLEN: dlen_r <= cfg_wdata[5:0];
        b2s_pkg::REG_KLEN: klen_r <= cfg_wdata[5:0];
        b2s_pkg::REG_SALT: salt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Message state.
  logic [63:0]    ctr_r;
  logic [6:0]     fill_r;
  logic [7:0][31:0] h_r;
  logic [5:0]     adlen_r;
  logic [31:0]    word_r;
  logic [2:0]     cnt_r;
  logic [2:0]     k_r;
  logic           eom_r;
  logic           final_r;

  // Compression state: the 4x4 vector as four rows, column 0 feeds the mixer.
  b2s_pkg::row_t  va_r, vb_r, vc_r, vd_r;
  logic [3:0]     rnd_r;
  logic [3:0]     step_r;
  logic [2:0]     ok_r;

  // Block buffer with byte writes and a registered word read.
  logic [31:0] buf_mem [16];
  logic [3:0]  rd_addr;
  logic [3:0]  rd_addr_r;
  logic [31:0] msg_r;
  logic [31:0] msg_m;
  logic        buf_we;

  assign buf_we = (state_r == ST_PUT) && (k_r != cnt_r) && (fill_r != b2s_pkg::BLOCK_BYTES);

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[fill_r[5:2]][{fill_r[1:0], 3'b000} +: 8] <= word_r[{k_r[1:0], 3'b000} +: 8];
    end
    msg_r     <= buf_mem[rd_addr];
    rd_addr_r <= rd_addr;
  end

  // Zero padding of the final block: bytes at or past the fill read as zero.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (final_r && ({1'b0, rd_addr_r, j[1:0]} >= fill_r)) begin
        msg_m[8*j +: 8] = 8'h00;
      end else begin
        msg_m[8*j +: 8] = msg_r[8*j +: 8];
      end
    end
  end

  // Next schedule position and its message word address.
  logic [3:0] rnd_nx;
  logic [3:0] step_nx;

  always_comb begin
    if (step_r == 4'd15) begin
      rnd_nx  = rnd_r + 4'd1;
      step_nx = 4'd0;
    end else begin
      rnd_nx  = rnd_r;
      step_nx = step_r + 4'd1;
    end
    if (state_r == ST_PRE) begin
      rd_addr = b2s_pkg::sigma(4'd0, 4'd0);
    end else begin
      rd_addr = b2s_pkg::sigma(rnd_nx, step_nx);
    end
  end

  // Mixing unit on column 0.
  b2s_pkg::quad_t mix_in;
  b2s_pkg::quad_t mix_out;

  assign mix_in.a = va_r[0];
  assign mix_in.b = vb_r[0];
  assign mix_in.c = vc_r[0];
  assign mix_in.d = vd_r[0];

  b2s_mix u_mix (
    .q_i      (mix_in),
    .x_i      (msg_m),
    .second_i (step_r[0]),
    .q_o      (mix_out)
  );

  function automatic b2s_pkg::row_t rotl(input b2s_pkg::row_t r, input logic [1:0] n);
    b2s_pkg::row_t o;
    for (int i = 0; i < 4; i++) begin
      o[i] = r[i[1:0] + n];
    end
    return o;
  endfunction

  // Row rotations after a step: the second half of each G moves to the next
  // column; after the column pass rows are skewed into diagonals, and the
  // skew is undone after the diagonal pass.
  logic [1:0] ra, rb, rc, rd;
  b2s_pkg::row_t ma, mb, mc, md;

  always_comb begin
    ma = va_r; mb = vb_r; mc = vc_r; md = vd_r;
    ma[0] = mix_out.a;
    mb[0] = mix_out.b;
    mc[0] = mix_out.c;
    md[0] = mix_out.d;
    if (!step_r[0]) begin
      ra = 2'd0; rb = 2'd0; rc = 2'd0; rd = 2'd0;
    end else if (step_r == 4'd7) begin
      ra = 2'd1; rb = 2'd2; rc = 2'd3; rd = 2'd0;
    end else if (step_r == 4'd15) begin
      ra = 2'd1; rb = 2'd0; rc = 2'd3; rd = 2'd2;
    end else begin
      ra = 2'd1; rb = 2'd1; rc = 2'd1; rd = 2'd1;
    end
  end

  // Chain reload values from the configuration.
  logic [5:0]  dl_c;
  logic [5:0]  kl_c;
  logic [2:0]  cnt_c;
  logic [7:0][31:0] h_init_c;

  always_comb begin
    dl_c = dlen_r;
    if (dlen_r == 6'd0) dl_c = 6'd1;
    if (dlen_r > b2s_pkg::MAX_DIGEST) dl_c = b2s_pkg::MAX_DIGEST;
    kl_c = (klen_r > b2s_pkg::MAX_KEY) ? b2s_pkg::MAX_KEY : klen_r;
    cnt_c = (in_tdata[34:32] > b2s_pkg::WORD_BYTES) ? b2s_pkg::WORD_BYTES : in_tdata[34:32];
    // The parameter word goes into chain word 0 and the salt into words 4 and 5.
    h_init_c    = b2s_pkg::B2S_IV;
    h_init_c[0] = b2s_pkg::B2S_IV[0] ^ {8'h01, 8'h01, 2'b00, kl_c, 2'b00, dl_c};
    h_init_c[4] = b2s_pkg::B2S_IV[4] ^ salt_r[31:0];
    h_init_c[5] = b2s_pkg::B2S_IV[5] ^ salt_r[63:32];
  end

  // Digest output.
  logic [5:0]  left_c;
  logic [2:0]  nb_c;
  logic [31:0] dw_c;

  always_comb begin
    left_c = adlen_r - {1'b0, ok_r, 2'b00};
    nb_c   = (left_c > 6'd4) ? b2s_pkg::WORD_BYTES : left_c[2:0];
    for (int j = 0; j < 4; j++) begin
      dw_c[8*j +: 8] = (j[2:0] < nb_c) ? h_r[ok_r][8*j +: 8] : 8'h00;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {5'b0, nb_c, dw_c};
  assign out_tlast  = (left_c <= 6'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ctr_r   <= '0;
      fill_r  <= '0;
      k_r     <= '0;
      cnt_r   <= '0;
      eom_r   <= 1'b0;
      final_r <= 1'b0;
      rnd_r   <= '0;
      step_r  <= '0;
      ok_r    <= '0;
      adlen_r <= MAX_DIGEST_C;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            word_r <= in_tdata[31:0];
            cnt_r  <= cnt_c;
            eom_r  <= in_tlast;
            k_r    <= '0;
            state_r <= ST_PUT;
            // A new message starts when nothing has been taken in yet.
            if ((ctr_r == 64'd0) && (fill_r == 7'd0)) begin
              adlen_r <= dl_c;
              h_r     <= h_init_c;
            end
          end
        end
        ST_PUT: begin
          if (k_r == cnt_r) begin
            if (eom_r) begin
              ctr_r   <= ctr_r + {57'd0, fill_r};
              final_r <= 1'b1;
              state_r <= ST_PRE;
            end else begin
              state_r <= ST_IDLE;
            end
          end else if (fill_r == b2s_pkg::BLOCK_BYTES) begin
            // A full block followed by another byte: compress it first.
            ctr_r   <= ctr_r + 64'd64;
            fill_r  <= '0;
            final_r <= 1'b0;
            state_r <= ST_PRE;
          end else begin
            fill_r <= fill_r + 7'd1;
            k_r    <= k_r + 3'd1;
          end
        end
        ST_PRE: begin
          va_r <= h_r[3:0];
          vb_r <= h_r[7:4];
          vc_r <= b2s_pkg::B2S_IV[3:0];
          vd_r <= {b2s_pkg::B2S_IV[7],
                   b2s_pkg::B2S_IV[6] ^ {32{final_r}},
                   b2s_pkg::B2S_IV[5] ^ ctr_r[63:32],
                   b2s_pkg::B2S_IV[4] ^ ctr_r[31:0]};
          rnd_r  <= '0;
          step_r <= '0;
          state_r <= ST_COMP;
        end
        ST_COMP: begin
          va_r <= rotl(ma, ra);
          vb_r <= rotl(mb, rb);
          vc_r <= rotl(mc, rc);
          vd_r <= rotl(md, rd);
          rnd_r  <= rnd_nx;
          step_r <= step_nx;
          if ((rnd_r == b2s_pkg::LAST_ROUND) && (step_r == 4'd15)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          for (int i = 0; i < 4; i++) begin
            h_r[i]     <= h_r[i] ^ va_r[i] ^ vc_r[i];
            h_r[i + 4] <= h_r[i + 4] ^ vb_r[i] ^ vd_r[i];
          end
          ok_r <= '0;
          state_r <= final_r ? ST_OUT : ST_PUT;
        end
        ST_OUT: begin
          if (out_tready) begin
            if (left_c <= 6'd4) begin
              ctr_r   <= '0;
              fill_r  <= '0;
              final_r <= 1'b0;
              state_r <= ST_IDLE;
            end else begin
              ok_r <= ok_r + 3'd1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: verif/b2s_checker.sv
// Checker for the BLAKE2s engine: watches the in, out and cfg channels, predicts digests and compares them.
`timescale 1ns / 100ps
module b2s_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
  } digest_item_t;

  localparam int SIG [10][16] = '{
    '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
    '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3},
    '{11, 8,12, 0, 5, 2,15,13,10,14, 3, 6, 7, 1, 9, 4},
    '{ 7, 9, 3, 1,13,12,11,14, 2, 6, 5,10, 4, 0,15, 8},
    '{ 9, 0, 5, 7, 2, 4,10,15,14, 1,11,12, 6, 8, 3,13},
    '{ 2,12, 6,10, 0,11, 8, 3, 4,13, 7, 5,15,14, 1, 9},
    '{12, 5, 1,15,14,13, 4,10, 0, 7, 6, 3, 9, 2, 8,11},
    '{13,11, 7,14,12, 1, 3, 9, 5, 0,15, 4, 8, 6, 2,10},
    '{ 6,15,14, 9,11, 3, 0, 8,12, 2,13, 7, 1, 4,10, 5},
    '{10, 2, 8, 4, 7, 6, 1, 5,15,11, 9,14, 3,12,13, 0}
  };

  logic [5:0]  dlen_reg, klen_reg;
  logic [63:0] salt_reg;
  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [63:0] total_bytes;
  int          fill;
  int          cur_dlen;
  digest_item_t digest_q [$];

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One compression of the block store into the chain.
  task automatic compress_block(bit is_final);
    logic [31:0] v [16];
    int a, b, c, d, r, g;
    int ga [8] = '{0, 1, 2, 3, 0, 1, 2, 3};
    int gb [8] = '{4, 5, 6, 7, 5, 6, 7, 4};
    int gc [8] = '{8, 9, 10, 11, 10, 11, 8, 9};
    int gd [8] = '{12, 13, 14, 15, 15, 12, 13, 14};
    for (int i = 0; i < 8; i++) begin
      v[i] = chain[i];
      v[i + 8] = b2s_pkg::B2S_IV[i];
    end
    v[12] ^= total_bytes[31:0];
    v[13] ^= total_bytes[63:32];
    if (is_final) v[14] = ~v[14];
    for (r = 0; r < 10; r++) begin
      for (g = 0; g < 8; g++) begin
        a = ga[g]; b = gb[g]; c = gc[g]; d = gd[g];
        v[a] = v[a] + v[b] + blk[SIG[r][2*g]];
        v[d] = ror(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = ror(v[b] ^ v[c], 12);
        v[a] = v[a] + v[b] + blk[SIG[r][2*g+1]];
        v[d] = ror(v[d] ^ v[a], 8);
        v[c] = v[c] + v[d];
        v[b] = ror(v[b] ^ v[c], 7);
      end
    end
    for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i + 8];
  endtask

  // Chain reload at message start: parameter word and salt folded into the IV.
  task automatic start_message();
    int dl, kl;
    dl = dlen_reg;
    kl = klen_reg;
    if (dl < 1) dl = 1;
    if (dl > 32) dl = 32;
    if (kl > 32) kl = 32;
    cur_dlen = dl;
    for (int i = 0; i < 8; i++) chain[i] = b2s_pkg::B2S_IV[i];
    chain[0] ^= dl | (kl << 8) | (1 << 16) | (1 << 24);
    chain[4] ^= salt_reg[31:0];
    chain[5] ^= salt_reg[63:32];
  endtask

  task automatic absorb_item(logic [31:0] w, logic [2:0] cnt_in, logic eom);
    int cnt, nw, left;
    digest_item_t e;
    logic [31:0] val;
    if (total_bytes == 0 && fill == 0) start_message();
    cnt = (cnt_in > 4) ? 4 : cnt_in;
    for (int k = 0; k < cnt; k++) begin
      if (fill >= 64) begin
        total_bytes += 64;
        compress_block(1'b0);
        fill = 0;
      end
      blk[fill / 4][(fill % 4) * 8 +: 8] = w[8 * k +: 8];
      fill++;
    end
    if (!eom) return;
    for (int k = fill; k < 64; k++) blk[k / 4][(k % 4) * 8 +: 8] = 8'h00;
    total_bytes += fill;
    compress_block(1'b1);
    nw = (cur_dlen + 3) / 4;
    for (int k = 0; k < nw; k++) begin
      left = cur_dlen - 4 * k;
      e.nbytes = (left > 4) ? 3'd4 : 3'(left);
      val = chain[k];
      if (e.nbytes < 4) val &= (32'd1 << (8 * e.nbytes)) - 1;
      e.word = val;
      e.last = (k + 1 == nw);
      digest_q.push_back(e);
    end
    total_bytes = 0;
    fill = 0;
    for (int i = 0; i < 16; i++) blk[i] = '0;
    start_message();
  endtask

  always @(posedge clk) begin
    digest_item_t e;
    if (!rst_n) begin
      dlen_reg <= 6'd32;
      klen_reg <= 6'd0;
      salt_reg <= '0;
      total_bytes = 0;
      fill = 0;
      cur_dlen = 32;
      for (int i = 0; i < 16; i++) blk[i] = '0;
      digest_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          b2s_pkg::REG_DLEN: dlen_reg <= cfg_wdata[5:0];
          b2s_pkg::REG_KLEN: klen_reg <= cfg_wdata[5:0];
          b2s_pkg::REG_SALT: salt_reg <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) absorb_item(in_tdata[31:0], in_tdata[34:32], in_tlast);
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected digest transfer data=%h last=%b", $realtime,
                     out_tdata, out_tlast);
        end else begin
          e = digest_q.pop_front();
          if (out_tdata[31:0] !== e.word || out_tdata[34:32] !== e.nbytes ||
              out_tdata[39:35] !== 5'd0 || out_tlast !== e.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: digest mismatch exp word=%h bytes=%0d last=%b got tdata=%h last=%b",
                       $realtime, e.word, e.nbytes, e.last, out_tdata, out_tlast);
          end
        end
      end
    end
    pending = digest_q.size();
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the BLAKE2s engine: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps
module tb_top;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  int          fail_count;
  int          pending;

  // Idle behavior: a calm stretch with no gaps at all, and long receiver hold-offs.
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;

  always #10 clk = ~clk;

  blake2s_hash_engine dut (.*);

  b2s_checker chk (.*);

  // The receiver stalls about thirty percent of the time, except in the calm stretch
  // and during the hold-off, when it refuses every transfer.
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= calm || ($urandom_range(99) >= 30);
  end

  // One input transfer; the sender may idle first, and valid stays high once offered.
  task automatic send_item(logic [31:0] w, logic [2:0] cnt, logic eom);
    while (!calm && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, cnt, w};
    in_tlast <= eom;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Between messages: let everything drain, then allow the engine's final latency.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A message of nwords full words with a random-length tail; long messages cross blocks.
  task automatic send_message(int nwords);
    for (int i = 0; i < nwords; i++) send_item($urandom, 3'd4, 1'b0);
    send_item($urandom, 3'($urandom_range(4)), 1'b1);
  endtask

  initial begin
    int sent;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with reset settings: empty message, field extremes, odd counts.
    send_item(32'h0, 3'd0, 1'b1);
    send_item(32'hFFFFFFFF, 3'd4, 1'b1);
    send_item(32'hFFFFFFFF, 3'd7, 1'b0);
    send_item(32'hA5A5A5A5, 3'd2, 1'b0);
    send_item(32'h5A5A5A5A, 3'd5, 1'b1);
    send_item(32'h12345678, 3'd1, 1'b0);
    send_item(32'h0, 3'd3, 1'b1);
    // Exactly one block, so the held-back block is compressed as the final one.
    for (int i = 0; i < 15; i++) send_item(32'hFFFFFFFF, 3'd4, 1'b0);
    send_item(32'h00000000, 3'd4, 1'b1);
    drain();

    // Out-of-range lengths, keyed run with the full key block, full salt.
    write_reg(b2s_pkg::REG_DLEN, 64'd0);
    write_reg(b2s_pkg::REG_KLEN, 64'd63);
    write_reg(b2s_pkg::REG_SALT, 64'hFFFFFFFFFFFFFFFF);
    send_message(17);
    drain();
    write_reg(b2s_pkg::REG_DLEN, 64'd63);
    write_reg(b2s_pkg::REG_KLEN, 64'd32);
    send_message(3);
    drain();

    // Random phases; the sender pauses at each drain until every digest word is out.
    sent = 0;
    while (sent < 210) begin
      write_reg(b2s_pkg::REG_DLEN, 64'($urandom_range(1, 32)));
      write_reg(b2s_pkg::REG_KLEN, 64'($urandom_range(0, 32)));
      write_reg(b2s_pkg::REG_SALT, {$urandom, $urandom});
      for (int m = 0; m < 4; m++) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 10);
        calm = (sent > 120 && sent < 160);
        // One message waits on the receiver long enough to fill the output and stall input.
        if (m == 1 && sent < 60) fork
          begin
            hold_off = 1'b1;
            repeat (600) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
        send_message(n);
        sent += n + 1;
      end
      calm = 1'b0;
      drain();
    end
    wait (!hold_off);
    drain();

    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #40ms;
    $display("tb_top: FAIL");
    $finish;
  end
endmodule
